/* design/btop_pkg.sv */
// ----------------------------------------------------------------------------
// Binomial tree pricer package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package btop_pkg;

  localparam logic [31:0] OneQ31 = 32'h8000_0000;
  localparam logic [31:0] Sat32  = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TERM,
    ST_INDUCT,
    ST_DRAIN,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the item operands
    logic term_init; // start a terminal price at the spot price
    logic term_mul;  // one multiply of the running price
    logic term_use_d;// multiply by d instead of u
    logic term_wr;   // write the payoff of the finished price
    logic rd;        // issue a read of the node store
    logic rd_first;  // this read is the first of a level
    logic ind_step;  // induction data is valid this cycle
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic busy;      // induction pipeline holds work
  } stat_t;

endpackage

/* design/btop_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module btop_ram #(
  parameter int Width = 32,
  parameter int Depth = 1025
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/btop_datapath.sv */
// ----------------------------------------------------------------------------
// Binomial tree pricer datapath
// Terminal price multiplier, payoff, node store and induction pipeline.
// ----------------------------------------------------------------------------
module btop_datapath #(
  parameter int AddrW = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  btop_pkg::cmd_t    cmd_i,
  input  logic [AddrW-1:0]  term_addr_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  input  logic [31:0]       spot_i,
  input  logic [31:0]       strike_i,
  input  logic [31:0]       up_i,
  input  logic [31:0]       down_i,
  input  logic [31:0]       prob_i,
  input  logic [31:0]       disc_i,
  input  logic              put_i,
  output btop_pkg::stat_t   stat_o,
  output logic [31:0]       value_o,
  output logic              sat_o
);

  logic [31:0] spot_q, strike_q, up_q, down_q, prob_q, qprob_q, disc_q;
  logic        put_q;
  logic [31:0] price_q;
  logic        sat_q, sat_d;

  // Terminal price path: one multiply per command.
  logic [63:0] tprod;
  logic [35:0] tshift;
  always_comb begin
    tprod  = 64'(price_q) * 64'(cmd_i.term_use_d ? down_q : up_q);
    tshift = tprod[63:28];
  end

  logic [31:0] payoff;
  always_comb begin
    if (put_q) payoff = (strike_q > price_q) ? strike_q - price_q : 32'd0;
    else       payoff = (price_q > strike_q) ? price_q - strike_q : 32'd0;
  end

  // Induction pipeline: read, read (second operand), blend, discount, write.
  logic [31:0] rdata;
  logic        vr_q;
  logic        v0_q, v1_q, v2_q, v3_q;
  logic        f1_q;
  logic [AddrW-1:0] a1_q, a2_q, a3_q, a4_q;
  logic [31:0] prev_q;
  logic [63:0] pa_q, pb_q;
  logic [32:0] e_q;
  logic [63:0] dprod_q;

  // Induction writes and terminal writes never overlap in time.
  logic [35:0] dshift;
  logic [31:0] dval;
  logic        dsat;
  always_comb begin
    dshift = dprod_q[62:27] >> 4;
    dsat   = v3_q && (dprod_q[63:31] > 33'(btop_pkg::Sat32));
    dval   = dsat ? btop_pkg::Sat32 : dprod_q[62:31];
  end

  logic             we;
  logic [AddrW-1:0] waddr;
  logic [31:0]      wdata;
  always_comb begin
    we    = cmd_i.term_wr | v3_q;
    waddr = v3_q ? a4_q : term_addr_i;
    wdata = v3_q ? dval : payoff;
  end

  btop_ram #(.Width(32), .Depth(2 ** AddrW)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(rd_addr_i),
    .rdata_o(rdata)
  );

  logic tsat;
  assign tsat = cmd_i.term_mul && (tshift[35:32] != 4'd0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      spot_q   <= spot_i;
      strike_q <= strike_i;
      up_q     <= up_i;
      down_q   <= down_i;
      prob_q   <= (prob_i > btop_pkg::OneQ31) ? btop_pkg::OneQ31 : prob_i;
      qprob_q  <= btop_pkg::OneQ31 -
                  ((prob_i > btop_pkg::OneQ31) ? btop_pkg::OneQ31 : prob_i);
      disc_q   <= disc_i;
      put_q    <= put_i;
    end
    if (cmd_i.term_init) begin
      price_q <= cmd_i.load ? spot_i : spot_q;
    end else if (cmd_i.term_mul) begin
      price_q <= tsat ? btop_pkg::Sat32 : tshift[31:0];
    end
    // Stage 1: read data of rd issued last cycle arrives now.
    a1_q <= rd_addr_i;
    if (vr_q) prev_q <= rdata;
    // Stage 2: both operands present once the second read lands.
    pa_q <= 64'(prob_q) * 64'(prev_q);
    pb_q <= 64'(qprob_q) * 64'(rdata);
    a2_q <= a1_q - AddrW'(1);
    a3_q <= a2_q;
    e_q  <= 33'((pa_q + pb_q) >> 31);
    a4_q <= a3_q;
    dprod_q <= 64'(disc_q) * 64'(e_q[31:0]);
  end

  // Valid chain: read issued -> data -> products -> sum -> discount product.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0; f1_q <= 1'b0; v1_q <= 1'b0; v2_q <= 1'b0;
      v3_q <= 1'b0; v0_q <= 1'b0; sat_q <= 1'b0;
    end else begin
      vr_q <= cmd_i.rd;
      f1_q <= cmd_i.rd_first;
      v1_q <= vr_q;
      v0_q <= vr_q & ~f1_q;
      v2_q <= v0_q;
      v3_q <= v2_q;
      sat_q <= sat_d;
    end
  end

  always_comb begin
    sat_d = sat_q | tsat | dsat;
    if (cmd_i.load) sat_d = 1'b0;
  end

  assign stat_o.busy = vr_q | v1_q | v0_q | v2_q | v3_q;
  assign value_o = rdata;
  assign sat_o   = sat_q;

  logic unused;
  assign unused = ^{dshift, e_q[32], cmd_i.ind_step};

endmodule

/* design/btop_ctrl.sv */
// ----------------------------------------------------------------------------
// Binomial tree pricer controller
// Sequences terminal prices, induction levels and the result transfer.
// ----------------------------------------------------------------------------
module btop_ctrl #(
  parameter int MaxSteps = 1024,
  parameter int AddrW    = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [10:0]       num_steps_i,
  input  logic              in_fire_i,
  input  logic              out_fire_i,
  input  btop_pkg::stat_t   stat_i,
  output btop_pkg::cmd_t    cmd_o,
  output logic [AddrW-1:0]  term_addr_o,
  output logic [AddrW-1:0]  rd_addr_o,
  output logic              in_ready_o,
  output logic              out_valid_o
);

  btop_pkg::state_e state_q, state_d;
  logic [AddrW-1:0] n_q, n_d;     // clamped step count
  logic [AddrW-1:0] i_q, i_d;     // terminal node / induction read index
  logic [AddrW-1:0] k_q, k_d;     // multiply count within a terminal price
  logic [AddrW-1:0] j_q, j_d;     // current induction level
  logic             pend_q, pend_d; // another induction level follows the drain

  logic [AddrW-1:0] n_clamp;
  assign n_clamp = (32'(num_steps_i) > MaxSteps) ? AddrW'(MaxSteps)
                                                  : AddrW'(num_steps_i);

  always_comb begin
    state_d = state_q;
    n_d = n_q; i_d = i_q; k_d = k_q; j_d = j_q; pend_d = 1'b0;
    cmd_o = '0;
    rd_addr_o = '0;
    term_addr_o = i_q;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      btop_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          cmd_o.term_init = 1'b1;
          n_d = n_clamp; i_d = '0; k_d = '0;
          state_d = btop_pkg::ST_TERM;
        end
      end
      btop_pkg::ST_TERM: begin
        // k counts multiplies done; n multiplies per node, the first n-i by u.
        if (k_q < n_q) begin
          cmd_o.term_mul = 1'b1;
          cmd_o.term_use_d = (k_q >= n_q - i_q);
          k_d = k_q + AddrW'(1);
        end else begin
          cmd_o.term_wr = 1'b1;
          cmd_o.term_init = 1'b1;
          k_d = '0;
          if (i_q == n_q) begin
            if (n_q == '0) begin
              state_d = btop_pkg::ST_DRAIN;
            end else begin
              j_d = n_q; i_d = '0;
              state_d = btop_pkg::ST_INDUCT;
            end
          end else begin
            i_d = i_q + AddrW'(1);
          end
        end
      end
      btop_pkg::ST_INDUCT: begin
        // Read 0..j each level; writes of i land after reads of i+1.
        cmd_o.rd = 1'b1;
        cmd_o.rd_first = (i_q == '0);
        rd_addr_o = i_q;
        if (i_q == j_q) begin
          i_d = '0;
          if (j_q == AddrW'(1)) begin
            state_d = btop_pkg::ST_DRAIN;
          end else begin
            j_d = j_q - AddrW'(1);
            // Let the last write of this level land before reading it again.
            state_d = btop_pkg::ST_DRAIN;
            pend_d = 1'b1;
          end
        end else begin
          i_d = i_q + AddrW'(1);
        end
      end
      btop_pkg::ST_DRAIN: begin
        rd_addr_o = '0;
        if (!stat_i.busy) begin
          state_d = pend_q ? btop_pkg::ST_INDUCT : btop_pkg::ST_OUT;
        end else begin
          pend_d = pend_q;
        end
      end
      btop_pkg::ST_OUT: begin
        rd_addr_o = '0;
        out_valid_o = 1'b1;
        if (out_fire_i) state_d = btop_pkg::ST_IDLE;
      end
      default: state_d = btop_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= btop_pkg::ST_IDLE;
      n_q <= '0; i_q <= '0; k_q <= '0; j_q <= '0; pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q <= n_d; i_q <= i_d; k_q <= k_d; j_q <= j_d; pend_q <= pend_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !stat_i.busy)
    else $error("result shown while induction pipeline busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == btop_pkg::ST_INDUCT) |-> (i_q <= j_q))
    else $error("induction index past level");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i |=> (state_q == btop_pkg::ST_TERM))
    else $error("accepted item did not start terminal phase");

endmodule

/* design/binomial_tree_option_pricer.sv */
// ----------------------------------------------------------------------------
// Binomial tree option pricer
// Prices one European call or put per item on a recombining binomial tree.
// ----------------------------------------------------------------------------
//   Channel   Direction  Content
//   s_axis    in         spot, strike, u, d, p, discount (tdata), is_put (tuser)
//   m_axis    out        option_value (tdata), saturated (tuser)
//   cfg       in         num_steps, 11 bits
//
// One item is worked on at a time. Terminal prices take one multiply of the
// running price per cycle, with a payoff write after each node. Induction
// takes one node read per cycle, set by the single node store read port, and
// drains the pipeline after each level.
// Reset leaves the block idle with num_steps at 64; the store needs no clearing.
// A stalled result holds until taken; no input is taken meanwhile.
// ----------------------------------------------------------------------------
module binomial_tree_option_pricer #(
  parameter int MAX_STEPS = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // spot_price[31:0], strike[63:32], up_factor[95:64], down_factor[127:96],
  // up_prob[159:128], step_discount[191:160]
  input  logic [191:0] s_axis_tdata,
  input  logic         s_axis_tuser, // is_put
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata, // option_value
  output logic         m_axis_tuser, // saturated
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [10:0]  cfg_data_i
);

  localparam int AddrW = $clog2(MAX_STEPS + 1);

  logic [10:0] num_steps_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) num_steps_q <= 11'd64;
    else if (cfg_valid_i) num_steps_q <= cfg_data_i;
  end
  assign cfg_ready_o = 1'b1;

  btop_pkg::cmd_t  cmd;
  btop_pkg::stat_t stat;
  logic [AddrW-1:0] term_addr, rd_addr;
  logic in_fire, out_fire;

  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign out_fire = m_axis_tvalid & m_axis_tready;

  btop_ctrl #(.MaxSteps(MAX_STEPS), .AddrW(AddrW)) u_ctrl (
    .clk_i, .rst_ni,
    .num_steps_i(num_steps_q),
    .in_fire_i  (in_fire),
    .out_fire_i (out_fire),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .term_addr_o(term_addr),
    .rd_addr_o  (rd_addr),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid)
  );

  btop_datapath #(.AddrW(AddrW)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i      (cmd),
    .term_addr_i(term_addr),
    .rd_addr_i  (rd_addr),
    .spot_i     (s_axis_tdata[31:0]),
    .strike_i   (s_axis_tdata[63:32]),
    .up_i       (s_axis_tdata[95:64]),
    .down_i     (s_axis_tdata[127:96]),
    .prob_i     (s_axis_tdata[159:128]),
    .disc_i     (s_axis_tdata[191:160]),
    .put_i      (s_axis_tuser),
    .stat_o     (stat),
    .value_o    (m_axis_tdata),
    .sat_o      (m_axis_tuser)
  );

endmodule
